// ===== design/sgi_pkg.sv =====
// Shared constants and control types for the segment intersection core.
package sgi_pkg;

    localparam int SGI_COORD_WIDTH = 16;

    typedef struct packed {
        logic valid;
        logic hit;
        logic q_neg;
        logic x_neg;
        logic y_neg;
    } sgi_ctl_t;

endpackage

// ===== design/sgi_front.sv =====
// Front pipeline: differences, cross products, cross terms and hit test.
module sgi_front #(
    parameter int W = sgi_pkg::SGI_COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [W-1:0]           a_start_x,
    input  logic [W-1:0]           a_start_y,
    input  logic [W-1:0]           a_end_x,
    input  logic [W-1:0]           a_end_y,
    input  logic [W-1:0]           b_start_x,
    input  logic [W-1:0]           b_start_y,
    input  logic [W-1:0]           b_end_x,
    input  logic [W-1:0]           b_end_y,
    output sgi_pkg::sgi_ctl_t      ctl,
    output logic [2*W+2:0]         ksi_mag,
    output logic [2*W+2:0]         delta_mag,
    output logic [1:0][W:0]        span_mag,
    output logic [1:0][W-1:0]      base
);
    import sgi_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int MW = 2 * W + 3;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    logic [W-1:0]         bx1_reg, by1_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg, pk1_reg, pk2_reg, pe1_reg, pe2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic [W-1:0]         bx2_reg, by2_reg;

    // stage 3: cross terms
    logic                 v3_reg;
    logic signed [MW-1:0] delta_reg, ksi_reg, eta_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic [W-1:0]         bx3_reg, by3_reg;

    // stage 4: classification
    sgi_ctl_t             ctl_reg, ctl_next;
    logic [MW-1:0]        km_reg, km_next, dm_reg, dm_next;
    logic [1:0][W:0]      sm_reg, sm_next;
    logic [1:0][W-1:0]    base_reg;

    logic [MW-1:0]        em;
    logic                 ksi_ok, eta_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= $signed({a_end_x[W-1], a_end_x}) - $signed({a_start_x[W-1], a_start_x});
        dy_reg  <= $signed({a_end_y[W-1], a_end_y}) - $signed({a_start_y[W-1], a_start_y});
        ex_reg  <= $signed({b_end_x[W-1], b_end_x}) - $signed({b_start_x[W-1], b_start_x});
        ey_reg  <= $signed({b_end_y[W-1], b_end_y}) - $signed({b_start_y[W-1], b_start_y});
        fx_reg  <= $signed({b_end_x[W-1], b_end_x}) - $signed({a_start_x[W-1], a_start_x});
        fy_reg  <= $signed({b_end_y[W-1], b_end_y}) - $signed({a_start_y[W-1], a_start_y});
        bx1_reg <= a_start_x;
        by1_reg <= a_start_y;

        pd1_reg <= PW'(dx_reg) * PW'(ey_reg);
        pd2_reg <= PW'(dy_reg) * PW'(ex_reg);
        pk1_reg <= PW'(ey_reg) * PW'(fx_reg);
        pk2_reg <= PW'(ex_reg) * PW'(fy_reg);
        pe1_reg <= PW'(dx_reg) * PW'(fy_reg);
        pe2_reg <= PW'(dy_reg) * PW'(fx_reg);
        dx2_reg <= dx_reg;
        dy2_reg <= dy_reg;
        bx2_reg <= bx1_reg;
        by2_reg <= by1_reg;

        delta_reg <= MW'(pd1_reg) - MW'(pd2_reg);
        ksi_reg   <= MW'(pk1_reg) - MW'(pk2_reg);
        eta_reg   <= MW'(pe1_reg) - MW'(pe2_reg);
        dx3_reg   <= dx2_reg;
        dy3_reg   <= dy2_reg;
        bx3_reg   <= bx2_reg;
        by3_reg   <= by2_reg;

        km_reg        <= km_next;
        dm_reg        <= dm_next;
        sm_reg        <= sm_next;
        base_reg[0]   <= bx3_reg;
        base_reg[1]   <= by3_reg;
    end

    always_comb
    begin
        km_next    = ksi_reg[MW-1] ? MW'(-ksi_reg) : MW'(ksi_reg);
        dm_next    = delta_reg[MW-1] ? MW'(-delta_reg) : MW'(delta_reg);
        em         = eta_reg[MW-1] ? MW'(-eta_reg) : MW'(eta_reg);
        sm_next[0] = dx3_reg[DW-1] ? DW'(-dx3_reg) : DW'(dx3_reg);
        sm_next[1] = dy3_reg[DW-1] ? DW'(-dy3_reg) : DW'(dy3_reg);
        ksi_ok     = (ksi_reg == '0) ||
                     ((ksi_reg[MW-1] == delta_reg[MW-1]) && (km_next <= dm_next));
        eta_ok     = (eta_reg == '0) ||
                     ((eta_reg[MW-1] == delta_reg[MW-1]) && (em <= dm_next));
        ctl_next.valid = v3_reg;
        ctl_next.hit   = (delta_reg != '0) && ksi_ok && eta_ok;
        ctl_next.q_neg = ksi_reg[MW-1] ^ delta_reg[MW-1];
        ctl_next.x_neg = dx3_reg[DW-1];
        ctl_next.y_neg = dy3_reg[DW-1];
    end

    assign ctl       = ctl_reg;
    assign ksi_mag   = km_reg;
    assign delta_mag = dm_reg;
    assign span_mag  = sm_reg;
    assign base      = base_reg;

endmodule

// ===== design/sgi_div_step.sv =====
// One radix-2 step of the ksi*span/delta quotient, both coordinate lanes.
module sgi_div_step #(
    parameter int W = sgi_pkg::SGI_COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sgi_pkg::sgi_ctl_t      ctl_in,
    input  logic [2*W+2:0]         k_in,
    input  logic [2*W+2:0]         d_in,
    input  logic [1:0][W:0]        m_in,
    input  logic [1:0][W:0]        q_in,
    input  logic [1:0][2*W+2:0]    r_in,
    input  logic [1:0][W-1:0]      base_in,
    output sgi_pkg::sgi_ctl_t      ctl_out,
    output logic [2*W+2:0]         k_out,
    output logic [2*W+2:0]         d_out,
    output logic [1:0][W:0]        m_out,
    output logic [1:0][W:0]        q_out,
    output logic [1:0][2*W+2:0]    r_out,
    output logic [1:0][W-1:0]      base_out
);
    import sgi_pkg::*;

    localparam int MW = 2 * W + 3;
    localparam int QW = W + 1;

    sgi_ctl_t           ctl_reg;
    logic [MW-1:0]      k_reg, d_reg;
    logic [1:0][QW-1:0] m_reg, m_next, q_reg, q_next;
    logic [1:0][MW-1:0] r_reg, r_next;
    logic [1:0][W-1:0]  base_reg;

    logic [MW+1:0]      d1, d2;
    logic [1:0][MW+1:0] t;

    always_comb
    begin
        d1 = {2'b00, d_in};
        d2 = {1'b0, d_in, 1'b0};
        for (int l = 0; l < 2; l++)
        begin
            t[l]      = {1'b0, r_in[l], 1'b0} + (m_in[l][QW-1] ? {2'b00, k_in} : '0);
            m_next[l] = {m_in[l][QW-2:0], 1'b0};
            if (t[l] >= d2)
            begin
                r_next[l] = MW'(t[l] - d2);
                q_next[l] = QW'({q_in[l], 1'b0} + (QW+1)'(2));
            end
            else if (t[l] >= d1)
            begin
                r_next[l] = MW'(t[l] - d1);
                q_next[l] = QW'({q_in[l], 1'b1});
            end
            else
            begin
                r_next[l] = MW'(t[l]);
                q_next[l] = QW'({q_in[l], 1'b0});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_in;
        d_reg         <= d_in;
        m_reg         <= m_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        base_reg      <= base_in;
    end

    assign ctl_out  = ctl_reg;
    assign k_out    = k_reg;
    assign d_out    = d_reg;
    assign m_out    = m_reg;
    assign q_out    = q_reg;
    assign r_out    = r_reg;
    assign base_out = base_reg;

endmodule

// ===== design/segment_intersection_core.sv =====
// Top level of the segment intersection core.
// One segment pair is taken every cycle; busy never rises. The result appears
// on crossing/point_x/point_y with done high for one cycle, once the request
// has passed four difference, product, cross term and hit stages, then
// COORD_WIDTH+1 quotient digit stages of the ksi*span/delta division and
// one output register.
// The receiver cannot stall; results must be captured when done is high.
module segment_intersection_core #(
    parameter int COORD_WIDTH = sgi_pkg::SGI_COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] a_start_x,
    input  logic [COORD_WIDTH-1:0] a_start_y,
    input  logic [COORD_WIDTH-1:0] a_end_x,
    input  logic [COORD_WIDTH-1:0] a_end_y,
    input  logic [COORD_WIDTH-1:0] b_start_x,
    input  logic [COORD_WIDTH-1:0] b_start_y,
    input  logic [COORD_WIDTH-1:0] b_end_x,
    input  logic [COORD_WIDTH-1:0] b_end_y,
    output logic                   done,
    output logic                   crossing,
    output logic [COORD_WIDTH-1:0] point_x,
    output logic [COORD_WIDTH-1:0] point_y
);
    import sgi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int MW  = 2 * W + 3;
    localparam int QW  = W + 1;
    localparam int LAT = W + 6;

    sgi_ctl_t           ctl_s  [0:QW];
    logic [MW-1:0]      k_s    [0:QW];
    logic [MW-1:0]      d_s    [0:QW];
    logic [1:0][QW-1:0] m_s    [0:QW];
    logic [1:0][QW-1:0] q_s    [0:QW];
    logic [1:0][MW-1:0] r_s    [0:QW];
    logic [1:0][W-1:0]  base_s [0:QW];

    logic               done_reg;
    logic               crossing_reg;
    logic [1:0][W-1:0]  point_reg, point_next;
    logic [1:0]         span_neg;

    assign busy = 1'b0;

    sgi_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .ctl       (ctl_s[0]),
        .ksi_mag   (k_s[0]),
        .delta_mag (d_s[0]),
        .span_mag  (m_s[0]),
        .base      (base_s[0])
    );

    assign q_s[0] = '0;
    assign r_s[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        sgi_div_step #(.W(W)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_s[i]),
            .k_in     (k_s[i]),
            .d_in     (d_s[i]),
            .m_in     (m_s[i]),
            .q_in     (q_s[i]),
            .r_in     (r_s[i]),
            .base_in  (base_s[i]),
            .ctl_out  (ctl_s[i+1]),
            .k_out    (k_s[i+1]),
            .d_out    (d_s[i+1]),
            .m_out    (m_s[i+1]),
            .q_out    (q_s[i+1]),
            .r_out    (r_s[i+1]),
            .base_out (base_s[i+1])
        );
    end

    always_comb
    begin
        span_neg[0] = ctl_s[QW].x_neg;
        span_neg[1] = ctl_s[QW].y_neg;
        for (int l = 0; l < 2; l++)
        begin
            if (!ctl_s[QW].hit)
                point_next[l] = '0;
            else if (ctl_s[QW].q_neg ^ span_neg[l])
                point_next[l] = W'({{2{base_s[QW][l][W-1]}}, base_s[QW][l]}
                                   - {1'b0, q_s[QW][l]});
            else
                point_next[l] = W'({{2{base_s[QW][l][W-1]}}, base_s[QW][l]}
                                   + {1'b0, q_s[QW][l]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_s[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        crossing_reg <= ctl_s[QW].hit;
        point_reg    <= point_next;
    end

    assign done     = done_reg;
    assign crossing = crossing_reg;
    assign point_x  = point_reg[0];
    assign point_y  = point_reg[1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request did not complete at fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s[QW].valid |-> $past(start, QW + 4))
        else $error("quotient pipeline valid without request");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !crossing) |-> (point_x == '0 && point_y == '0))
        else $error("miss result carries nonzero point");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for segment_intersection_core: random and directed segment pairs.
module tb_top;
    import sgi_pkg::*;

    localparam int W = SGI_COORD_WIDTH;
    localparam int LATENCY = W + 6;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        bit           drain;
    } seg_pair_t;

    typedef struct {
        logic         hit;
        logic [W-1:0] px, py;
    } isect_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
    logic [W-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
    logic         done;
    logic         crossing;
    logic [W-1:0] point_x, point_y;

    seg_pair_t pending_pairs[$];
    isect_t    expected_isects[$];
    int        errors = 0;
    int        gap_left = 0;
    int        idle_cycles = 0;
    bit        stim_done = 0;

    segment_intersection_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_start_x(a_start_x), .a_start_y(a_start_y),
        .a_end_x(a_end_x), .a_end_y(a_end_y),
        .b_start_x(b_start_x), .b_start_y(b_start_y),
        .b_end_x(b_end_x), .b_end_y(b_end_y),
        .done(done), .crossing(crossing), .point_x(point_x), .point_y(point_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ratio num/den in [0,1], den nonzero
    function automatic bit ratio_in_unit(longint num, longint den);
        if (num == 0)
            return 1;
        if ((num < 0) != (den < 0))
            return 0;
        return (num < 0 ? -num : num) <= (den < 0 ? -den : den);
    endfunction

    function automatic isect_t predict_isect(seg_pair_t p);
        isect_t r;
        longint dx, dy, ex, ey, fx, fy, delta, ksi, eta;
        dx = longint'($signed(p.ax2)) - longint'($signed(p.ax1));
        dy = longint'($signed(p.ay2)) - longint'($signed(p.ay1));
        ex = longint'($signed(p.bx2)) - longint'($signed(p.bx1));
        ey = longint'($signed(p.by2)) - longint'($signed(p.by1));
        fx = longint'($signed(p.bx2)) - longint'($signed(p.ax1));
        fy = longint'($signed(p.by2)) - longint'($signed(p.ay1));
        delta = dx * ey - dy * ex;
        ksi = ey * fx - ex * fy;
        eta = dx * fy - dy * fx;
        r.hit = 1'b0;
        r.px = '0;
        r.py = '0;
        if (delta != 0 && ratio_in_unit(ksi, delta) && ratio_in_unit(eta, delta))
        begin
            r.hit = 1'b1;
            r.px = W'(longint'($signed(p.ax1)) + (ksi * dx) / delta);
            r.py = W'(longint'($signed(p.ay1)) + (ksi * dy) / delta);
        end
        return r;
    endfunction

    function automatic seg_pair_t make_pair(int ax1, int ay1, int ax2, int ay2,
                                            int bx1, int by1, int bx2, int by2);
        seg_pair_t p;
        p.ax1 = W'(ax1); p.ay1 = W'(ay1); p.ax2 = W'(ax2); p.ay2 = W'(ay2);
        p.bx1 = W'(bx1); p.by1 = W'(by1); p.bx2 = W'(bx2); p.by2 = W'(by2);
        p.drain = 0;
        return p;
    endfunction

    function automatic logic [W-1:0] rand_coord(int mode);
        case (mode)
            0: return W'($urandom);
            1: return W'($urandom_range(0, 512) - 256);
            2: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
            default: return W'($urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    initial
    begin
        seg_pair_t p;
        int mode;
        pending_pairs.push_back(make_pair(-16, 0, 16, 0, 0, -16, 0, 16));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
        pending_pairs.push_back(make_pair(0, 0, 16, 0, 0, 16, 16, 16));
        pending_pairs.push_back(make_pair(0, 0, 32, 0, 16, 0, 48, 0));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 16, 16, 32, 0));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 0, 32, 0));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 0, 32, -16, 32, 16));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(3, 0, -7, 5, 0, 4, 1, -9));
        pending_pairs[pending_pairs.size()-1].drain = 1;
        for (int i = 0; i < 400; i++)
        begin
            mode = $urandom_range(0, 3);
            p.ax1 = rand_coord(mode); p.ay1 = rand_coord(mode);
            p.ax2 = rand_coord(mode); p.ay2 = rand_coord(mode);
            if ($urandom_range(0, 2) != 0)
            begin
                // force a likely crossing: B starts near A's midpoint, its end mirrored through (ax1, 0)
                p.bx1 = W'((int'($signed(p.ax1)) + int'($signed(p.ax2))) / 2
                           + $urandom_range(0, 60) - 30);
                p.by1 = W'((int'($signed(p.ay1)) + int'($signed(p.ay2))) / 2
                           + $urandom_range(0, 600) - 300);
                p.bx2 = W'(2 * int'($signed(p.ax1)) - int'($signed(p.bx1))
                           + $urandom_range(0, 6));
                p.by2 = W'(-int'($signed(p.by1)) + $urandom_range(0, 6));
            end
            else
            begin
                p.bx1 = rand_coord(mode); p.by1 = rand_coord(mode);
                p.bx2 = rand_coord(mode); p.by2 = rand_coord(mode);
            end
            p.drain = (i == 200);
            pending_pairs.push_back(p);
        end
        stim_done = 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seg_pair_t q;
                q.ax1 = a_start_x; q.ay1 = a_start_y; q.ax2 = a_end_x; q.ay2 = a_end_y;
                q.bx1 = b_start_x; q.by1 = b_start_y; q.bx2 = b_end_x; q.by2 = b_end_y;
                expected_isects.push_back(predict_isect(q));
            end
            if (start && !busy || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].drain &&
                           (expected_isects.size() > 0 || start)))
                begin
                    seg_pair_t p;
                    p = pending_pairs.pop_front();
                    a_start_x <= p.ax1; a_start_y <= p.ay1;
                    a_end_x <= p.ax2; a_end_y <= p.ay2;
                    b_start_x <= p.bx1; b_start_y <= p.by1;
                    b_end_x <= p.bx2; b_end_y <= p.by2;
                    start <= 1'b1;
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            isect_t e;
            if (expected_isects.size() == 0)
            begin
                $display("%0t: unexpected result crossing=%b x=%h y=%h",
                         $time, crossing, point_x, point_y);
                errors++;
            end
            else
            begin
                e = expected_isects.pop_front();
                if (crossing !== e.hit)
                begin
                    $display("%0t: crossing expected %b actual %b", $time, e.hit, crossing);
                    errors++;
                end
                if (point_x !== e.px)
                begin
                    $display("%0t: point_x expected %h actual %h", $time, e.px, point_x);
                    errors++;
                end
                if (point_y !== e.py)
                begin
                    $display("%0t: point_y expected %h actual %h", $time, e.py, point_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_pairs.size() == 0 && !start);
        wait (expected_isects.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_isects.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/sgi_pkg.sv
design/sgi_front.sv
design/sgi_div_step.sv
design/segment_intersection_core.sv
dv/tb_top.sv
